// ===== rtl/core/vfm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the voxel face-culling mesher.
// Used by the register bank, controller, datapath and top level; no dependencies.

package vfm_pkg;

  // Voxel store geometry: 32 x 32 x 32 cells, address {x, y, z}
  localparam int COORD_W     = 5;
  localparam int ADDR_W      = 3 * COORD_W;
  localparam int VOXELS      = 1 << ADDR_W;
  localparam int SIZE_W      = 6;
  localparam int COLOR_W     = 32;
  localparam int VCNT_W      = 20;
  localparam int STEP_W      = 3;
  localparam int NUM_FACES   = 6;
  localparam int MAX_DIM_DEF = 32;

  // Read sequence: centre cell first, then the six neighbours
  localparam logic [STEP_W-1:0] STEP_CTR  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_NXM  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_NXP  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_NYM  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_NYP  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_NZM  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_NZP  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_NZP;

  // Item opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MESH  = 1'b1;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
  } sizes_t;

  // Controller to datapath
  typedef struct packed {
    logic wr;    // write the input voxel into the store
    logic load;  // latch a meshing transaction
    logic rd;    // issue the store read for the current step
    logic emit;  // load the next face into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rd_done;     // last neighbour read is being issued
    logic mask_empty;  // no exposed faces left
    logic mask_one;    // at most one exposed face left (exactly one when the mask is not empty)
    logic out_free;    // output register can take a face this cycle
  } sts_t;

endpackage

// ===== rtl/core/vfm_cfg_regs.sv =====
`timescale 1ns / 1ps
// APB-style register bank holding the three grid size registers.
// Depends on vfm_pkg for the register index codes and the sizes struct.

module vfm_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output vfm_pkg::sizes_t     sizes_o
);

  vfm_pkg::sizes_t sizes_q, sizes_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Decode the write
  always_comb begin
    sizes_d = sizes_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        vfm_pkg::REG_SIZE_X: sizes_d.size_x = pwdata[vfm_pkg::SIZE_W-1:0];
        vfm_pkg::REG_SIZE_Y: sizes_d.size_y = pwdata[vfm_pkg::SIZE_W-1:0];
        vfm_pkg::REG_SIZE_Z: sizes_d.size_z = pwdata[vfm_pkg::SIZE_W-1:0];
        default: sizes_d = sizes_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sizes_q.size_x <= 6'd32;
      sizes_q.size_y <= 6'd32;
      sizes_q.size_z <= 6'd32;
    end else begin
      sizes_q <= sizes_d;
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      vfm_pkg::REG_SIZE_X: prdata = {26'd0, sizes_q.size_x};
      vfm_pkg::REG_SIZE_Y: prdata = {26'd0, sizes_q.size_y};
      vfm_pkg::REG_SIZE_Z: prdata = {26'd0, sizes_q.size_z};
      default: prdata = '0;
    endcase
  end

  assign sizes_o = sizes_q;

endmodule

// ===== rtl/core/vfm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences store writes, the seven store reads of a
// meshing transaction and the face emission. Depends on vfm_pkg.

module vfm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          op_i,
  output logic          in_stall_o,
  input  vfm_pkg::sts_t sts_i,
  output vfm_pkg::cmd_t cmd_o
);

  vfm_pkg::state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vfm_pkg::S_IDLE: begin
        if (in_valid_i && op_i == vfm_pkg::OP_MESH) state_d = vfm_pkg::S_READ;
      end
      vfm_pkg::S_READ: begin
        if (sts_i.rd_done) state_d = vfm_pkg::S_DRAIN;
      end
      vfm_pkg::S_DRAIN: begin
        state_d = vfm_pkg::S_EMIT;
      end
      vfm_pkg::S_EMIT: begin
        if (sts_i.mask_empty) begin
          state_d = vfm_pkg::S_IDLE;
        end else if (sts_i.out_free && sts_i.mask_one) begin
          state_d = vfm_pkg::S_IDLE;
        end
      end
      default: state_d = vfm_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      vfm_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.wr   = in_valid_i && op_i == vfm_pkg::OP_WRITE;
        cmd_o.load = in_valid_i && op_i == vfm_pkg::OP_MESH;
      end
      vfm_pkg::S_READ: begin
        cmd_o.rd = 1'b1;
      end
      vfm_pkg::S_DRAIN: begin
        cmd_o = '0;
      end
      vfm_pkg::S_EMIT: begin
        cmd_o.emit = !sts_i.mask_empty && sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vfm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/vfm_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: single-port voxel store, neighbour address generation, exposed-face
// mask, vertex counter and the output register. Depends on vfm_pkg.

module vfm_datapath #(
  parameter int MAX_DIM = vfm_pkg::MAX_DIM_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  vfm_pkg::cmd_t                       cmd_i,
  output vfm_pkg::sts_t                       sts_o,
  input  vfm_pkg::sizes_t                     sizes_i,
  input  logic [vfm_pkg::COORD_W-1:0]         pos_x_i,
  input  logic [vfm_pkg::COORD_W-1:0]         pos_y_i,
  input  logic [vfm_pkg::COORD_W-1:0]         pos_z_i,
  input  logic                                present_i,
  input  logic [vfm_pkg::COLOR_W-1:0]         paint_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          face_o,
  output logic signed [6:0]                   out_a_o,
  output logic [5:0]                          out_b_o,
  output logic signed [6:0]                   out_c_o,
  output logic [vfm_pkg::COLOR_W-1:0]         face_color_o,
  output logic [vfm_pkg::VCNT_W-1:0]          first_vertex_o,
  output logic                                last_o
);

  localparam int                        CAP_INT  = (MAX_DIM < 32) ? MAX_DIM : 32;
  localparam logic [vfm_pkg::SIZE_W-1:0] SIZE_CAP = vfm_pkg::SIZE_W'(CAP_INT);

  // Zero acts as one, large values saturate to the cap
  function automatic logic [vfm_pkg::SIZE_W-1:0] eff_size(
    input logic [vfm_pkg::SIZE_W-1:0] r
  );
    logic [vfm_pkg::SIZE_W-1:0] e;
    if (r == '0) e = 6'd1;
    else if (r > SIZE_CAP) e = SIZE_CAP;
    else e = r;
    return e;
  endfunction

  logic [vfm_pkg::SIZE_W-1:0]  sx, sy, sz;
  logic [vfm_pkg::COORD_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [vfm_pkg::COORD_W-1:0] nx, ny, nz;
  logic [vfm_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
  logic [vfm_pkg::COLOR_W:0]   store_mem [vfm_pkg::VOXELS];
  logic [vfm_pkg::COLOR_W:0]   rdata_q;
  logic [vfm_pkg::STEP_W-1:0]  step_q, rd_idx_q, face_sel;
  logic                        rd_vld_q;
  logic                        ctr_in, ctr_solid_q;
  logic [vfm_pkg::NUM_FACES-1:0] nb_in, mask_q, mask_low, mask_rest;
  logic [vfm_pkg::COLOR_W-1:0] color_q;
  logic [2:0]                  face_code;
  logic [vfm_pkg::VCNT_W-1:0]  vcnt_q;
  logic                        out_vld_q, out_free;
  logic [2:0]                  face_q;
  logic [6:0]                  out_a_q, out_c_q;
  logic [5:0]                  out_b_q;
  logic [vfm_pkg::COLOR_W-1:0] color_out_q;
  logic [vfm_pkg::VCNT_W-1:0]  first_vertex_q;
  logic                        last_q;

  assign sx = eff_size(sizes_i.size_x);
  assign sy = eff_size(sizes_i.size_y);
  assign sz = eff_size(sizes_i.size_z);

  // Latch the meshed position
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_x_q <= pos_x_i;
      pos_y_q <= pos_y_i;
      pos_z_q <= pos_z_i;
    end
  end

  // Step the read sequence and track which read returns next
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= vfm_pkg::STEP_CTR;
      rd_idx_q <= vfm_pkg::STEP_CTR;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd;
      if (cmd_i.load) begin
        step_q <= vfm_pkg::STEP_CTR;
      end else if (cmd_i.rd) begin
        step_q   <= step_q + 3'd1;
        rd_idx_q <= step_q;
      end
    end
  end

  // Neighbour coordinates for the current step, wrapping inside the store
  always_comb begin
    nx = pos_x_q;
    ny = pos_y_q;
    nz = pos_z_q;
    case (step_q)
      vfm_pkg::STEP_NXM: nx = pos_x_q - 5'd1;
      vfm_pkg::STEP_NXP: nx = pos_x_q + 5'd1;
      vfm_pkg::STEP_NYM: ny = pos_y_q - 5'd1;
      vfm_pkg::STEP_NYP: ny = pos_y_q + 5'd1;
      vfm_pkg::STEP_NZM: nz = pos_z_q - 5'd1;
      vfm_pkg::STEP_NZP: nz = pos_z_q + 5'd1;
      default: nx = pos_x_q;
    endcase
  end

  assign wr_addr = {pos_x_i, pos_y_i, pos_z_i};
  assign rd_addr = {nx, ny, nz};

  // Single-port voxel store: exist flag over colour
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      store_mem[wr_addr] <= {present_i, paint_i};
    end else if (cmd_i.rd) begin
      rdata_q <= store_mem[rd_addr];
    end
  end

  // Grid membership of the centre and of each neighbour
  assign ctr_in = ({1'b0, pos_x_q} < sx) && ({1'b0, pos_y_q} < sy) &&
                  ({1'b0, pos_z_q} < sz);
  assign nb_in[0] = pos_x_q != '0;
  assign nb_in[1] = ({1'b0, pos_x_q} + 6'd1) < sx;
  assign nb_in[2] = pos_y_q != '0;
  assign nb_in[3] = ({1'b0, pos_y_q} + 6'd1) < sy;
  assign nb_in[4] = pos_z_q != '0;
  assign nb_in[5] = ({1'b0, pos_z_q} + 6'd1) < sz;

  assign face_sel = rd_idx_q - 3'd1;

  // Pick the lowest exposed face
  assign mask_low  = mask_q & (~mask_q + 6'd1);
  assign mask_rest = mask_q & ~mask_low;

  always_comb begin
    face_code = '0;
    for (int i = 0; i < vfm_pkg::NUM_FACES; i++) begin
      if (mask_low[i]) face_code = 3'(i);
    end
  end

  // Build the exposed mask from returning reads, drop faces as they go out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      ctr_solid_q <= 1'b0;
    end else if (cmd_i.load) begin
      mask_q      <= '0;
      ctr_solid_q <= 1'b0;
    end else if (rd_vld_q) begin
      if (rd_idx_q == vfm_pkg::STEP_CTR) begin
        ctr_solid_q <= rdata_q[vfm_pkg::COLOR_W] && ctr_in;
      end else begin
        mask_q[face_sel] <= ctr_solid_q &&
                            !(nb_in[face_sel] && rdata_q[vfm_pkg::COLOR_W]);
      end
    end else if (cmd_i.emit) begin
      mask_q <= mask_rest;
    end
  end

  // Hold the centre colour
  always_ff @(posedge clk_i) begin
    if (rd_vld_q && rd_idx_q == vfm_pkg::STEP_CTR) begin
      color_q <= rdata_q[vfm_pkg::COLOR_W-1:0];
    end
  end

  // Running first-vertex index, four per face
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= '0;
    end else if (cmd_i.emit) begin
      vcnt_q <= vcnt_q + 20'd4;
    end
  end

  // Output register
  assign out_free = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      face_q         <= face_code;
      out_a_q        <= {1'b0, sx} - {1'b0, pos_x_q, 1'b0};
      out_b_q        <= {pos_z_q, 1'b0};
      out_c_q        <= {1'b0, pos_y_q, 1'b0} - {1'b0, sy};
      color_out_q    <= color_q;
      first_vertex_q <= vcnt_q;
      last_q         <= mask_rest == '0;
    end
  end

  assign sts_o.rd_done    = cmd_i.rd && step_q == vfm_pkg::STEP_LAST;
  assign sts_o.mask_empty = mask_q == '0;
  assign sts_o.mask_one   = mask_rest == '0;
  assign sts_o.out_free   = out_free;

  assign out_valid_o    = out_vld_q;
  assign face_o         = face_q;
  assign out_a_o        = $signed(out_a_q);
  assign out_b_o        = out_b_q;
  assign out_c_o        = $signed(out_c_q);
  assign face_color_o   = color_out_q;
  assign first_vertex_o = first_vertex_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/core/voxel_face_culling_mesher.sv =====
`timescale 1ns / 1ps
// Top level of the voxel face-culling mesher: register bank, controller and
// datapath. Depends on vfm_pkg, vfm_cfg_regs, vfm_ctrl and vfm_datapath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per item.
//   op_i = 0 writes exist flag and colour at (pos_x_i, pos_y_i, pos_z_i); it is
//   taken while the controller is idle and gives no result. op_i = 1 meshes one
//   voxel: the store has one port, so the centre and its six neighbours are
//   read one a cycle, the drain state then takes in the last read, and one
//   exposed face leaves per cycle while the receiver does not stall. last_o
//   marks the final face of the item.
//   Output channel (out_valid_o / out_stall_i) has a registered face; while
//   the receiver stalls, the face holds and emission pauses. A new input is
//   taken as soon as the controller is idle, even if the last face still waits.
//   The user writes grid sizes over the APB-style port only while the block is
//   idle; the block itself does not enforce this.
//   Reset clears the controller, the vertex index and the sizes (32 each); the
//   voxel store is not cleared and must be written before it is read.

module voxel_face_culling_mesher #(
  parameter int MAX_DIM = vfm_pkg::MAX_DIM_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        op_i,
  input  logic [4:0]                  pos_x_i,
  input  logic [4:0]                  pos_y_i,
  input  logic [4:0]                  pos_z_i,
  input  logic                        present_i,
  input  logic [31:0]                 paint_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  face_o,
  output logic signed [6:0]           out_a_o,
  output logic [5:0]                  out_b_o,
  output logic signed [6:0]           out_c_o,
  output logic [31:0]                 face_color_o,
  output logic [19:0]                 first_vertex_o,
  output logic                        last_o
);

  vfm_pkg::sizes_t sizes;
  vfm_pkg::cmd_t   cmd;
  vfm_pkg::sts_t   sts;

  vfm_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .sizes_o (sizes)
  );

  vfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vfm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sizes_i        (sizes),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .present_i      (present_i),
    .paint_i        (paint_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .face_o         (face_o),
    .out_a_o        (out_a_o),
    .out_b_o        (out_b_o),
    .out_c_o        (out_c_o),
    .face_color_o   (face_color_o),
    .first_vertex_o (first_vertex_o),
    .last_o         (last_o)
  );

  // A face never overwrites one that is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("face emitted over a stalled result");

  // The store port is never asked to write and read together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr && cmd.rd))
    else $error("store write and read in the same cycle");

  // After a meshing transaction is taken the input stays stalled as the reads begin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && op_i == vfm_pkg::OP_MESH) |=> in_stall_o ##1 in_stall_o)
    else $error("input taken during neighbour reads");

endmodule
